FILE: rtl/midb_pkg.sv
package midb_pkg;

    // pin count and the pin that also takes the extra detect line
    localparam int NUM_INPUTS  = 32;
    localparam int SPECIAL_PIN = 25;

    // field widths
    localparam int SAMPLE_W   = 32;
    localparam int COUNT_W    = 8;
    localparam int INDEX_W    = 6;
    localparam int BYTE_SEL_W = 3;
    localparam int PAD_W      = 64;

    // bytes of stable state that a read can return
    localparam int STATE_BYTES = (NUM_INPUTS + 7) / 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // operation codes
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // per-pin control for one transfer
    typedef struct packed {
        logic               tick;
        logic               wr;
        logic               en;
        logic [COUNT_W-1:0] ticks;
    } pin_ctrl_t;

endpackage

FILE: rtl/midb_cell.sv
module midb_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  midb_pkg::pin_ctrl_t ctrl,
    input  logic                sample,
    output logic                stable_level,
    output logic                stable_level_next
);
    import midb_pkg::*;

    logic               stable_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               enable_reg;
    logic [COUNT_W-1:0] time_reg;
    logic               enable_next;
    logic [COUNT_W-1:0] time_next;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] limit;

    // debounce step for one tick
    always_comb
    begin
        limit             = enable_reg ? time_reg : '0;
        count_inc         = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;
        stable_level_next = stable_reg;
        count_next        = count_reg;
        if (ctrl.tick)
        begin
            if (sample != stable_reg)
            begin
                if (count_inc >= limit)
                begin
                    stable_level_next = sample;
                    count_next        = '0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            else
            begin
                count_next = '0;
            end
        end
    end

    // settings write
    always_comb
    begin
        enable_next = enable_reg;
        time_next   = time_reg;
        if (ctrl.wr)
        begin
            enable_next = ctrl.en;
            time_next   = ctrl.ticks;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg <= 1'b0;
            count_reg  <= '0;
            enable_reg <= 1'b0;
            time_reg   <= '0;
        end
        else
        begin
            stable_reg <= stable_level_next;
            count_reg  <= count_next;
            enable_reg <= enable_next;
            time_reg   <= time_next;
        end
    end

    assign stable_level = stable_reg;

endmodule

FILE: rtl/multichannel_input_debouncer_unit.sv
// Multichannel input debouncer: one counter-based debounce cell per pin.
// Input channel (in_valid / in_stall) carries one operation per transfer:
// a tick with raw samples for every pin, a write of one pin's enable flag
// and debounce time, or a read of one byte of the stable levels.
// Output channel (out_valid / out_stall) returns exactly one result per
// input transfer: read_byte (zero unless a read) and the stable levels
// after the operation.
// An item passes through the input register, then through the pin cells into
// the result register. Throughput is one transfer per cycle when out_stall is
// low, set by the single pass through the per-pin compare and increment.
// When the receiver stalls, the result register holds its item and the
// input register still takes one more transfer before in_stall rises.
// Reset clears the stable levels, counters, enable flags and debounce
// times of every pin, and empties both registers.
module multichannel_input_debouncer_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         operation,
    input  logic [midb_pkg::SAMPLE_W-1:0]      pin_samples,
    input  logic                               extra_detect,
    input  logic [midb_pkg::INDEX_W-1:0]       channel_index,
    input  logic                               debounce_enable,
    input  logic [midb_pkg::COUNT_W-1:0]       debounce_ticks,
    input  logic [midb_pkg::BYTE_SEL_W-1:0]    byte_index,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [7:0]                         read_byte,
    output logic [midb_pkg::SAMPLE_W-1:0]      stable_vector
);
    import midb_pkg::*;

    logic                  in_valid_reg;
    logic                  in_valid_next;
    op_t                   op_reg;
    logic [SAMPLE_W-1:0]   samples_reg;
    logic                  extra_reg;
    logic [INDEX_W-1:0]    index_reg;
    logic                  enable_reg;
    logic [COUNT_W-1:0]    ticks_reg;
    logic [BYTE_SEL_W-1:0] byte_sel_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [7:0]            read_byte_reg;
    logic [7:0]            read_byte_next;
    logic [SAMPLE_W-1:0]   stable_vector_reg;

    logic                  accept;
    logic                  advance;
    logic [NUM_INPUTS-1:0] stable_now;
    logic [NUM_INPUTS-1:0] stable_next;
    logic [PAD_W-1:0]      stable_pad;
    logic [PAD_W-1:0]      stable_next_pad;

    // handshake: the item moves on when the result register is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        out_valid_next = advance || (out_valid_reg && out_stall);
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= op_t'(operation);
            samples_reg  <= pin_samples;
            extra_reg    <= extra_detect;
            index_reg    <= channel_index;
            enable_reg   <= debounce_enable;
            ticks_reg    <= debounce_ticks;
            byte_sel_reg <= byte_index;
        end
    end

    // one debounce cell per pin
    for (genvar n = 0; n < NUM_INPUTS; n++)
    begin : g_pin
        pin_ctrl_t ctrl;
        logic      sample;

        assign ctrl.tick  = advance && (op_reg == OP_TICK);
        assign ctrl.wr    = advance && (op_reg == OP_WRITE)
                            && (index_reg == INDEX_W'(n));
        assign ctrl.en    = enable_reg;
        assign ctrl.ticks = ticks_reg;

        if (n < SAMPLE_W && n == SPECIAL_PIN)
        begin : g_special
            assign sample = samples_reg[n] | extra_reg;
        end
        else if (n < SAMPLE_W)
        begin : g_plain
            assign sample = samples_reg[n];
        end
        else if (n == SPECIAL_PIN)
        begin : g_special_high
            assign sample = extra_reg;
        end
        else
        begin : g_high
            assign sample = 1'b0;
        end

        midb_cell u_cell (
            .clk               (clk),
            .rst_n             (rst_n),
            .ctrl              (ctrl),
            .sample            (sample),
            .stable_level      (stable_now[n]),
            .stable_level_next (stable_next[n])
        );
    end

    // byte read of the stable levels
    assign stable_pad      = PAD_W'(stable_now);
    assign stable_next_pad = PAD_W'(stable_next);

    always_comb
    begin
        read_byte_next = '0;
        if (op_reg == OP_READ && 32'(byte_sel_reg) < STATE_BYTES)
            read_byte_next = stable_pad[{byte_sel_reg, 3'b000} +: 8];
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            read_byte_reg     <= read_byte_next;
            stable_vector_reg <= stable_next_pad[SAMPLE_W-1:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_byte     = read_byte_reg;
    assign stable_vector = stable_vector_reg;

endmodule

FILE: test/tb_multichannel_input_debouncer_unit.sv
module tb_multichannel_input_debouncer_unit;

    import midb_pkg::*;

    localparam int HOLD_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1425;
    localparam int HOLD_START     = 700;
    localparam int HOLD_END       = 960;
    localparam int PRESSURE_AT    = 300;
    localparam int DIR_ROWS       = 25;
    localparam int PIN_SEL_W      = $clog2(NUM_INPUTS);

    // one operation offered on the input channel
    typedef struct packed {
        op_t                    op;
        logic [SAMPLE_W-1:0]    samples;
        logic                   extra;
        logic [INDEX_W-1:0]     idx;
        logic                   en;
        logic [COUNT_W-1:0]     ticks;
        logic [BYTE_SEL_W-1:0]  bidx;
    } debounce_req_t;

    // one result returned on the output channel
    typedef struct packed {
        logic [7:0]             rd;
        logic [SAMPLE_W-1:0]    vec;
    } debounce_res_t;

    // directed row: typed result is used only where fixed is set
    typedef struct packed {
        debounce_req_t          req;
        logic                   fixed;
        debounce_res_t          res;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [1:0]             operation = 2'd0;
    logic [SAMPLE_W-1:0]    pin_samples = '0;
    logic                   extra_detect = 1'b0;
    logic [INDEX_W-1:0]     channel_index = '0;
    logic                   debounce_enable = 1'b0;
    logic [COUNT_W-1:0]     debounce_ticks = '0;
    logic [BYTE_SEL_W-1:0]  byte_index = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [7:0]             read_byte;
    logic [SAMPLE_W-1:0]    stable_vector;

    // predictor state
    logic [SAMPLE_W-1:0]    stable_lv;
    logic [COUNT_W-1:0]     change_cnt [NUM_INPUTS];
    logic                   pin_en     [NUM_INPUTS];
    logic [COUNT_W-1:0]     pin_time   [NUM_INPUTS];

    debounce_res_t          pending_results [$];

    bit                     quiet = 1'b0;
    bit                     hold_req = 1'b0;
    bit                     hold_served = 1'b0;
    int                     mismatches = 0;
    int                     results_seen = 0;
    int                     n_ticks = 0;
    int                     n_writes = 0;
    int                     n_reads = 0;
    int                     n_other = 0;
    int                     idle_cycles = 0;

    multichannel_input_debouncer_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .pin_samples     (pin_samples),
        .extra_detect    (extra_detect),
        .channel_index   (channel_index),
        .debounce_enable (debounce_enable),
        .debounce_ticks  (debounce_ticks),
        .byte_index      (byte_index),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .read_byte       (read_byte),
        .stable_vector   (stable_vector)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // debounce behaviour of one operation, updating the predictor state
    function automatic debounce_res_t debounce_predict(input debounce_req_t req);
        debounce_res_t      res;
        logic               cur;
        logic [COUNT_W-1:0] limit;
        res = '0;
        case (req.op)
            OP_TICK:
            begin
                for (int n = 0; n < NUM_INPUTS; n++)
                begin
                    cur = req.samples[n];
                    if (n == SPECIAL_PIN && req.extra)
                        cur = 1'b1;
                    limit = pin_en[n] ? pin_time[n] : '0;
                    if (cur != stable_lv[n])
                    begin
                        if (change_cnt[n] != COUNT_MAX)
                            change_cnt[n] = change_cnt[n] + 1'b1;
                        if (change_cnt[n] >= limit)
                        begin
                            stable_lv[n]  = cur;
                            change_cnt[n] = '0;
                        end
                    end
                    else
                        change_cnt[n] = '0;
                end
            end
            OP_WRITE:
            begin
                if (int'(req.idx) < NUM_INPUTS)
                begin
                    pin_en[req.idx[PIN_SEL_W-1:0]]   = req.en;
                    pin_time[req.idx[PIN_SEL_W-1:0]] = req.ticks;
                end
            end
            OP_READ:
            begin
                if (int'(req.bidx) < STATE_BYTES)
                    res.rd = stable_lv[int'(req.bidx) * 8 +: 8];
            end
            default: ;
        endcase
        res.vec = stable_lv;
        return res;
    endfunction

    // offer one transfer and record its expected result once taken
    task automatic send_item(input debounce_req_t req, input logic fixed,
                             input debounce_res_t typed_res);
        debounce_res_t pred;
        if (!quiet && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        operation       <= req.op;
        pin_samples     <= req.samples;
        extra_detect    <= req.extra;
        channel_index   <= req.idx;
        debounce_enable <= req.en;
        debounce_ticks  <= req.ticks;
        byte_index      <= req.bidx;
        do
            @(posedge clk);
        while (in_stall);
        pred = debounce_predict(req);
        pending_results.push_back(fixed ? typed_res : pred);
        case (req.op)
            OP_TICK:  n_ticks++;
            OP_WRITE: n_writes++;
            OP_READ:  n_reads++;
            default:  n_other++;
        endcase
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endtask

    // receiver stalls, with one long hold-off to back the block up
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_served)
            begin
                hold_served = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (quiet)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 10);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        debounce_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                note_mismatch("unexpected transfer", 32'h0, stable_vector);
            else
            begin
                want = pending_results.pop_front();
                if (read_byte !== want.rd)
                    note_mismatch("read_byte", 32'(want.rd), 32'(read_byte));
                if (stable_vector !== want.vec)
                    note_mismatch("stable_vector", want.vec, stable_vector);
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        stim_row_t      dir_table [DIR_ROWS];
        debounce_req_t  req;
        logic [31:0]    target;
        logic [31:0]    hold_target;
        int unsigned    roll;

        // reset clears the predictor as well
        stable_lv = '0;
        for (int n = 0; n < NUM_INPUTS; n++)
        begin
            change_cnt[n] = '0;
            pin_en[n]     = 1'b0;
            pin_time[n]   = '0;
        end

        // directed rows: reset state, extremes, ignored writes, out-of-range
        // reads, zero time, lowered time, the extra detect line
        dir_table = '{
            '{'{OP_READ,  32'h0000_0000, 1'b0, 6'd0,  1'b0, 8'd0,   3'd0}, 1'b1,
              '{8'h00, 32'h0000_0000}},
            '{'{OP_NONE,  32'hFFFF_FFFF, 1'b1, 6'd63, 1'b1, 8'd255, 3'd7}, 1'b1,
              '{8'h00, 32'h0000_0000}},
            '{'{OP_TICK,  32'hFFFF_FFFF, 1'b0, 6'd0,  1'b0, 8'd0,   3'd0}, 1'b1,
              '{8'h00, 32'hFFFF_FFFF}},
            '{'{OP_READ,  32'h0000_0000, 1'b0, 6'd0,  1'b0, 8'd0,   3'd3}, 1'b1,
              '{8'hFF, 32'hFFFF_FFFF}},
            '{'{OP_READ,  32'h0000_0000, 1'b0, 6'd0,  1'b0, 8'd0,   3'd7}, 1'b1,
              '{8'h00, 32'hFFFF_FFFF}},
            '{'{OP_READ,  32'h0000_0000, 1'b0, 6'd0,  1'b0, 8'd0,   3'd4}, 1'b1,
              '{8'h00, 32'hFFFF_FFFF}},
            '{'{OP_TICK,  32'h0000_0000, 1'b1, 6'd0,  1'b0, 8'd0,   3'd0}, 1'b1,
              '{8'h00, 32'h0200_0000}},
            '{'{OP_TICK,  32'h0000_0000, 1'b0, 6'd0,  1'b0, 8'd0,   3'd0}, 1'b1,
              '{8'h00, 32'h0000_0000}},
            '{'{OP_WRITE, 32'h0000_0000, 1'b0, 6'd63, 1'b1, 8'd255, 3'd0}, 1'b1,
              '{8'h00, 32'h0000_0000}},
            '{'{OP_WRITE, 32'h0000_0000, 1'b0, 6'd32, 1'b1, 8'd3,   3'd0}, 1'b1,
              '{8'h00, 32'h0000_0000}},
            '{'{OP_WRITE, 32'h0000_0000, 1'b0, 6'd0,  1'b1, 8'd3,   3'd0}, 1'b0, '0},
            '{'{OP_WRITE, 32'h0000_0000, 1'b0, 6'd31, 1'b1, 8'd255, 3'd0}, 1'b0, '0},
            '{'{OP_WRITE, 32'h0000_0000, 1'b0, 6'd25, 1'b1, 8'd2,   3'd0}, 1'b0, '0},
            '{'{OP_WRITE, 32'h0000_0000, 1'b0, 6'd5,  1'b1, 8'd0,   3'd0}, 1'b0, '0},
            '{'{OP_TICK,  32'h8000_0021, 1'b0, 6'd0,  1'b0, 8'd0,   3'd0}, 1'b0, '0},
            '{'{OP_TICK,  32'h8000_0021, 1'b0, 6'd0,  1'b0, 8'd0,   3'd0}, 1'b0, '0},
            '{'{OP_TICK,  32'h0000_0000, 1'b1, 6'd0,  1'b0, 8'd0,   3'd0}, 1'b0, '0},
            '{'{OP_TICK,  32'h0000_0001, 1'b1, 6'd0,  1'b0, 8'd0,   3'd0}, 1'b0, '0},
            '{'{OP_WRITE, 32'h0000_0000, 1'b0, 6'd0,  1'b1, 8'd1,   3'd0}, 1'b0, '0},
            '{'{OP_TICK,  32'h0000_0001, 1'b0, 6'd0,  1'b0, 8'd0,   3'd0}, 1'b0, '0},
            '{'{OP_WRITE, 32'h0000_0000, 1'b0, 6'd0,  1'b0, 8'd200, 3'd0}, 1'b0, '0},
            '{'{OP_TICK,  32'h0000_0000, 1'b0, 6'd0,  1'b0, 8'd0,   3'd0}, 1'b0, '0},
            '{'{OP_READ,  32'h0000_0000, 1'b0, 6'd0,  1'b0, 8'd0,   3'd2}, 1'b0, '0},
            '{'{OP_TICK,  32'hFFFF_FFFF, 1'b1, 6'd0,  1'b0, 8'd0,   3'd0}, 1'b0, '0},
            '{'{OP_READ,  32'h0000_0000, 1'b0, 6'd0,  1'b0, 8'd0,   3'd0}, 1'b0, '0}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i])
            send_item(dir_table[i].req, dir_table[i].fixed, dir_table[i].res);

        // random part: a slowly moving pin pattern with glitches on top
        target      = $urandom;
        hold_target = '0;
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            req.samples = $urandom;
            req.extra   = 1'($urandom_range(1));
            req.idx     = INDEX_W'($urandom_range(63));
            req.en      = 1'($urandom_range(1));
            req.ticks   = COUNT_W'($urandom_range(255));
            req.bidx    = BYTE_SEL_W'($urandom_range(7));

            if (k == PRESSURE_AT)
                hold_req = 1'b1;

            if (k == HOLD_START)
            begin
                // slowest pin gets the longest time, then a steady pattern
                req.op    = OP_WRITE;
                req.idx   = 6'd31;
                req.en    = 1'b1;
                req.ticks = COUNT_MAX;
                hold_target = $urandom;
                hold_target[31] = ~stable_lv[31];
                quiet = 1'b1;
            end
            else if (k > HOLD_START && k < HOLD_END)
            begin
                req.op      = OP_TICK;
                req.samples = hold_target;
                req.extra   = 1'b0;
            end
            else
            begin
                quiet = 1'b0;
                roll  = $urandom_range(99);
                if (roll < 70)
                begin
                    req.op = OP_TICK;
                    if ($urandom_range(29) == 0)
                        target = target ^ $urandom;
                    req.samples = target;
                    if ($urandom_range(1) == 1)
                        req.samples = target ^ ($urandom & $urandom & $urandom);
                    req.extra = ($urandom_range(3) == 0);
                end
                else if (roll < 82)
                begin
                    req.op = OP_WRITE;
                    if ($urandom_range(9) < 7)
                        req.ticks = COUNT_W'($urandom_range(6));
                    req.en = ($urandom_range(4) != 0);
                end
                else if (roll < 97)
                    req.op = OP_READ;
                else
                    req.op = OP_NONE;
            end
            send_item(req, 1'b0, '0);
        end
        in_valid <= 1'b0;
        quiet = 1'b0;

        // drain, then allow the pipeline to settle
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d ticks, %0d setting writes, %0d byte reads, %0d unused codes",
                 n_ticks, n_writes, n_reads, n_other);
        $display("checked %0d results, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
